// ===== src/progress_slot_min_tracker_defines.svh =====
// Assertion macros shared by the files of the progress slot tracker.
// They expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef PROGRESS_SLOT_MIN_TRACKER_DEFINES_SVH
`define PROGRESS_SLOT_MIN_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PST_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pst_pkg.sv =====
`default_nettype none

package pst_pkg;

	localparam int unsigned VAL_W = 64;
	localparam int unsigned CNT_W = 5;

	localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;
	localparam logic [VAL_W-1:0] ALL_ONES  = {VAL_W{1'b1}};

	// Command codes; the two remaining codes change nothing.
	typedef enum logic [2:0] {
		CMD_REGISTER   = 3'd0,
		CMD_UNREGISTER = 3'd1,
		CMD_ENTER_WAIT = 3'd2,
		CMD_LEAVE_WAIT = 3'd3,
		CMD_UPDATE     = 3'd4,
		CMD_COMPUTE    = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH,
		ST_MIN,
		ST_MDRAIN,
		ST_MEND,
		ST_WB
	} state_t;

endpackage

`default_nettype wire

// ===== src/pst_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module pst_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/progress_slot_min_tracker.sv =====
// Worker progress slot table with a minimum tracker. Each item is one command
// (register, unregister, enter wait, leave wait, update progress, compute
// minimum) and gives exactly one result, which carries the grant for a
// register, the minimum for a compute, and in every case the number of active
// slots and the running worker count after the command. Items are taken one at
// a time: in_ready is high only while the sequencer is idle, and a finished
// result sits in an output register so that the next command can be taken
// while the result waits for its transfer. Unregister, enter wait, leave wait,
// update progress and unknown codes go from execution straight to the result;
// register walks the active flags one slot per cycle until it finds the lowest
// free slot or reaches the last one; compute minimum sweeps the progress
// memory through its single read port one slot per cycle into one shared
// 64-bit comparator. Progress values live in a RAM with no reset; a slot only
// counts toward the minimum while its active flag is set, and every way of
// setting that flag also writes the slot's progress, so entries never written
// are never looked at.
`default_nettype none

module progress_slot_min_tracker #(
	parameter int unsigned SLOT_COUNT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  command,
	input  wire logic        slot_present,
	input  wire logic [3:0]  slot,
	input  wire logic [63:0] progress_value,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             granted,
	output logic [3:0]       granted_slot,
	output logic [63:0]      min_progress,
	output logic [4:0]       live_slots,
	output logic [4:0]       registered_count
);

`include "progress_slot_min_tracker_defines.svh"

	localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
	localparam int unsigned ACT_W = $clog2(SLOT_COUNT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	// Sequencer state.
	pst_pkg::state_t state_q, state_d;

	// Captured command.
	logic [2:0]  cmd_q;
	logic        present_q;
	logic [3:0]  slot_q;
	logic [63:0] value_q;

	// Slot table control state.
	logic [SLOT_COUNT-1:0] active_q;
	logic [ACT_W-1:0]      act_cnt_q;
	logic [4:0]            worker_q;
	logic [63:0]           cached_q;

	// Scan index shared by the free-slot search and the minimum sweep.
	logic [IDX_W-1:0] idx_q;

	// Minimum sweep: read stage and accumulator.
	logic        rd_vld_s1;
	logic        rd_act_s1;
	logic [63:0] best_q;
	logic [1:0]  seen_q;

	// Result of the current command before it moves to the output register.
	logic        granted_q;
	logic [3:0]  gslot_q;
	logic [63:0] minp_q;

	logic        out_valid_q;
	logic        load_out;

	// Progress memory ports.
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [63:0]      ram_wdata;
	logic [63:0]      ram_rdata;

	logic             named;
	logic [IDX_W-1:0] slot_idx;

	// A slot is named only if present and inside the table.
	assign named    = present_q && (32'(slot_q) < SLOT_COUNT);
	assign slot_idx = IDX_W'(slot_q);
	assign load_out = (state_q == pst_pkg::ST_WB) && (!out_valid_q || out_ready);

	pst_ram #(
		.WIDTH(pst_pkg::VAL_W),
		.DEPTH(SLOT_COUNT)
	) u_progress_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pst_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = pst_pkg::ST_EXEC;
				end
			end
			pst_pkg::ST_EXEC: begin
				unique case (cmd_q)
					pst_pkg::CMD_REGISTER: state_d = pst_pkg::ST_SEARCH;
					pst_pkg::CMD_COMPUTE:  state_d = pst_pkg::ST_MIN;
					default:               state_d = pst_pkg::ST_WB;
				endcase
			end
			pst_pkg::ST_SEARCH: begin
				if (!active_q[idx_q] || idx_q == LAST_IDX) begin
					state_d = pst_pkg::ST_WB;
				end
			end
			pst_pkg::ST_MIN: begin
				if (idx_q == LAST_IDX) begin
					state_d = pst_pkg::ST_MDRAIN;
				end
			end
			pst_pkg::ST_MDRAIN: state_d = pst_pkg::ST_MEND;
			pst_pkg::ST_MEND:   state_d = pst_pkg::ST_WB;
			pst_pkg::ST_WB: begin
				if (!out_valid_q || out_ready) begin
					state_d = pst_pkg::ST_IDLE;
				end
			end
			default: state_d = pst_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: input handshake and the memory write port.
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = cached_q;
		unique case (state_q)
			pst_pkg::ST_IDLE: in_ready = 1'b1;
			pst_pkg::ST_EXEC: begin
				unique case (cmd_q)
					pst_pkg::CMD_LEAVE_WAIT: begin
						ram_we    = named;
						ram_waddr = slot_idx;
						ram_wdata = cached_q;
					end
					pst_pkg::CMD_UPDATE: begin
						ram_we    = named;
						ram_waddr = slot_idx;
						ram_wdata = value_q;
					end
					default: ;
				endcase
			end
			pst_pkg::ST_SEARCH: begin
				// The claimed slot is seeded with the cached minimum.
				ram_we    = !active_q[idx_q];
				ram_waddr = idx_q;
				ram_wdata = cached_q;
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pst_pkg::ST_IDLE;
			active_q    <= '0;
			act_cnt_q   <= '0;
			worker_q    <= '0;
			cached_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == pst_pkg::ST_MIN);

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				pst_pkg::ST_EXEC: begin
					unique case (cmd_q)
						pst_pkg::CMD_UNREGISTER: begin
							if (named) begin
								if (active_q[slot_idx]) begin
									active_q[slot_idx] <= 1'b0;
									act_cnt_q          <= act_cnt_q - ACT_W'(1);
								end
								// The count goes down even for an inactive slot.
								if (worker_q != '0) begin
									worker_q <= worker_q - 5'd1;
								end
							end
						end
						pst_pkg::CMD_ENTER_WAIT: begin
							if (named && active_q[slot_idx]) begin
								active_q[slot_idx] <= 1'b0;
								act_cnt_q          <= act_cnt_q - ACT_W'(1);
							end
						end
						pst_pkg::CMD_LEAVE_WAIT: begin
							if (named && !active_q[slot_idx]) begin
								active_q[slot_idx] <= 1'b1;
								act_cnt_q          <= act_cnt_q + ACT_W'(1);
							end
						end
						default: ;
					endcase
				end
				pst_pkg::ST_SEARCH: begin
					if (!active_q[idx_q]) begin
						active_q[idx_q] <= 1'b1;
						act_cnt_q       <= act_cnt_q + ACT_W'(1);
						if (worker_q != pst_pkg::COUNT_MAX) begin
							worker_q <= worker_q + 5'd1;
						end
					end
				end
				pst_pkg::ST_MEND: begin
					// With no active slot the cached minimum is kept.
					if (seen_q != 2'd0) begin
						cached_q <= best_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q     <= command;
			present_q <= slot_present;
			slot_q    <= slot;
			value_q   <= progress_value;
		end

		rd_act_s1 <= active_q[idx_q];

		// Shared comparator: fold one read slot per cycle into the minimum.
		if (rd_vld_s1 && rd_act_s1) begin
			if (ram_rdata < best_q) begin
				best_q <= ram_rdata;
			end
			if (seen_q != 2'd2) begin
				seen_q <= seen_q + 2'd1;
			end
		end

		unique case (state_q)
			pst_pkg::ST_EXEC: begin
				idx_q     <= '0;
				best_q    <= pst_pkg::ALL_ONES;
				seen_q    <= 2'd0;
				granted_q <= 1'b0;
				gslot_q   <= '0;
				minp_q    <= '0;
			end
			pst_pkg::ST_SEARCH: begin
				if (!active_q[idx_q]) begin
					granted_q <= 1'b1;
					gslot_q   <= 4'(idx_q);
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			pst_pkg::ST_MIN: idx_q <= idx_q + IDX_W'(1);
			pst_pkg::ST_MEND: begin
				// A single active slot reports all ones.
				minp_q <= (seen_q == 2'd2) ? best_q : pst_pkg::ALL_ONES;
			end
			default: ;
		endcase

		if (load_out) begin
			granted          <= granted_q;
			granted_slot     <= gslot_q;
			min_progress     <= minp_q;
			live_slots       <= 5'(act_cnt_q);
			registered_count <= worker_q;
		end
	end

	assign out_valid = out_valid_q;

	// The incremental active count always matches the flags.
	`PST_ASSERT_SAME(a_act_cnt, 1'b1, act_cnt_q == ACT_W'($countones(active_q)), "active count mismatch")

	// Nothing in the table changes while the sequencer is idle.
	`PST_ASSERT_NEXT(a_idle_quiet, state_q == pst_pkg::ST_IDLE, $stable(worker_q) && $stable(active_q), "table changed while idle")

	// Read data only enters the comparator after a sweep cycle.
	`PST_ASSERT_NEXT(a_rd_src, state_q != pst_pkg::ST_MIN, !rd_vld_s1, "stray read in comparator")

endmodule

`default_nettype wire

// ===== test/progress_slot_min_tracker_tb.sv =====
`timescale 1ns / 1ps

// One result as the block reports it, one field per output port.
typedef struct packed {
	logic        granted;
	logic [3:0]  granted_slot;
	logic [63:0] min_progress;
	logic [4:0]  live_slots;
	logic [4:0]  registered_count;
} tracker_result_t;

// Keeps its own copy of the slot table and predicts the result of every
// command that the block takes. Results come back in command order.
class slot_table_scoreboard;
	bit              slot_active [16];
	logic [63:0]     slot_progress [16];
	logic [63:0]     cached_min;
	logic [4:0]      workers;
	tracker_result_t expected_results [$];
	int unsigned     errors;

	function new();
		foreach (slot_active[i]) begin
			slot_active[i] = 1'b0;
			slot_progress[i] = '0;
		end
		cached_min = '0;
		workers = '0;
		errors = 0;
	endfunction

	function int unsigned pending();
		return expected_results.size();
	endfunction

	task report_mismatch(string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		errors++;
	endtask

	function void note_command(logic [2:0] op, logic present, logic [3:0] index,
			logic [63:0] value);
		tracker_result_t res;
		logic [63:0]     best;
		int unsigned     live;
		bit              named;

		res = '0;
		named = present && (index < 16);
		case (op)
		pst_pkg::CMD_REGISTER: begin
			for (int i = 0; i < 16; i++) begin
				if (!res.granted && !slot_active[i]) begin
					slot_active[i] = 1'b1;
					slot_progress[i] = cached_min;
					if (workers < pst_pkg::COUNT_MAX)
						workers++;
					res.granted = 1'b1;
					res.granted_slot = i[3:0];
				end
			end
		end
		pst_pkg::CMD_UNREGISTER: begin
			if (named) begin
				slot_active[index] = 1'b0;
				if (workers != 0)
					workers--;
			end
		end
		pst_pkg::CMD_ENTER_WAIT: begin
			if (named)
				slot_active[index] = 1'b0;
		end
		pst_pkg::CMD_LEAVE_WAIT: begin
			if (named) begin
				slot_progress[index] = cached_min;
				slot_active[index] = 1'b1;
			end
		end
		pst_pkg::CMD_UPDATE: begin
			if (named)
				slot_progress[index] = value;
		end
		pst_pkg::CMD_COMPUTE: begin
			best = pst_pkg::ALL_ONES;
			live = 0;
			for (int i = 0; i < 16; i++) begin
				if (slot_active[i]) begin
					if (slot_progress[i] < best)
						best = slot_progress[i];
					live++;
				end
			end
			if (live != 0)
				cached_min = best;
			res.min_progress = (live >= 2) ? best : pst_pkg::ALL_ONES;
		end
		default: begin
		end
		endcase

		live = 0;
		foreach (slot_active[i])
			if (slot_active[i])
				live++;
		res.live_slots = live[4:0];
		res.registered_count = workers;
		expected_results.push_back(res);
	endfunction

	task check_result(tracker_result_t got);
		tracker_result_t want;

		if (expected_results.size() == 0) begin
			report_mismatch("result arrived with no command outstanding");
		end else begin
			want = expected_results.pop_front();
			if (got.granted !== want.granted)
				report_mismatch($sformatf("granted %0b, want %0b", got.granted,
					want.granted));
			if (got.granted_slot !== want.granted_slot)
				report_mismatch($sformatf("granted_slot %0d, want %0d",
					got.granted_slot, want.granted_slot));
			if (got.min_progress !== want.min_progress)
				report_mismatch($sformatf("min_progress %h, want %h",
					got.min_progress, want.min_progress));
			if (got.live_slots !== want.live_slots)
				report_mismatch($sformatf("live_slots %0d, want %0d",
					got.live_slots, want.live_slots));
			if (got.registered_count !== want.registered_count)
				report_mismatch($sformatf("registered_count %0d, want %0d",
					got.registered_count, want.registered_count));
		end
	endtask
endclass

module progress_slot_min_tracker_tb;

	localparam int unsigned SLOTS = 16;
	// The drain wait is sized from the slowest command, compute.
	localparam int unsigned DRAIN_CYCLES = 3 * (SLOTS + 4);
	// Roughly 1100 commands plus the long hold-off on the result side fit many
	// times over in this bound.
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned RANDOM_COMMANDS = 1050;
	// Window of accepted commands that run with no idling on either side.
	localparam int unsigned QUIET_FROM = 600;
	localparam int unsigned QUIET_TO = 800;
	// After this many accepted commands the result side holds off for a long stretch.
	localparam int unsigned HOLD_AT = 300;
	localparam int unsigned HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  command = '0;
	logic        slot_present = 1'b0;
	logic [3:0]  slot = '0;
	logic [63:0] progress_value = '0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        granted;
	logic [3:0]  granted_slot;
	logic [63:0] min_progress;
	logic [4:0]  live_slots;
	logic [4:0]  registered_count;

	int unsigned cycle_count = 0;
	int unsigned accepted_count = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	slot_table_scoreboard occupancy_sb;

	progress_slot_min_tracker #(
		.SLOT_COUNT(SLOTS)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.slot_present    (slot_present),
		.slot            (slot),
		.progress_value  (progress_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.granted         (granted),
		.granted_slot    (granted_slot),
		.min_progress    (min_progress),
		.live_slots      (live_slots),
		.registered_count(registered_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Global watchdog. A hang anywhere, including results that never come back,
	// ends the run here as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
				occupancy_sb.pending());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Input monitor. Every input transfer is handed to the scoreboard, which
	// updates its table and queues the one result this command must produce.
	// All signals read here change only through nonblocking assignments, so the
	// values seen are the ones present at the clock edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			occupancy_sb.note_command(command, slot_present, slot, progress_value);
			accepted_count <= accepted_count + 1;
		end
	end

	// Output monitor. Every result transfer is compared with the oldest
	// prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			occupancy_sb.check_result('{granted, granted_slot, min_progress,
				live_slots, registered_count});
	end

	// Result side. It normally stalls at random, about 17 percent of the time,
	// never stalls during the quiet window, and once holds off long enough that
	// the result register fills and the block stops taking commands while the
	// sender keeps offering them.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (!hold_done && accepted_count >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (accepted_count >= QUIET_FROM && accepted_count < QUIET_TO) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 17);
		end
	end

	// Offers one command and returns at the clock edge where it is transferred.
	// Called at a rising edge. Valid is lowered only for an idle gap before the
	// command, so it is never dropped and raised again in the same time step.
	task automatic send_command(logic [2:0] op, logic present, logic [3:0] index,
			logic [63:0] value);
		bit quiet;

		quiet = (accepted_count >= QUIET_FROM && accepted_count < QUIET_TO);
		if (!quiet && $urandom_range(99) < 17) begin
			// Gaps up to about the compute latency land on every phase of the sequencer.
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= op;
		slot_present <= present;
		slot <= index;
		progress_value <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Progress values lean toward the extremes and small numbers so that ties
	// and near-ties in the minimum show up, while full random words still toggle
	// every bit.
	function automatic logic [63:0] pick_progress();
		case ($urandom_range(5))
		0: return '0;
		1: return pst_pkg::ALL_ONES;
		2: return 64'($urandom_range(15));
		3: return {1'b1, 63'($urandom_range(7))};
		default: return {$urandom, $urandom};
		endcase
	endfunction

	// Command mix. Growing phases favor register and enter wait, so the table
	// fills, registers start to fail and the worker count climbs into its
	// ceiling; shrinking phases favor unregister, driving the count down to
	// zero, where it holds. Codes 6 and 7 appear now and then.
	function automatic logic [2:0] pick_command(bit growing);
		int unsigned roll;

		roll = $urandom_range(99);
		if (roll < 4)
			return 3'($urandom_range(6, 7));
		if (growing) begin
			if (roll < 44) return pst_pkg::CMD_REGISTER;
			if (roll < 47) return pst_pkg::CMD_UNREGISTER;
			if (roll < 67) return pst_pkg::CMD_ENTER_WAIT;
			if (roll < 75) return pst_pkg::CMD_LEAVE_WAIT;
			if (roll < 88) return pst_pkg::CMD_UPDATE;
			return pst_pkg::CMD_COMPUTE;
		end
		if (roll < 14) return pst_pkg::CMD_REGISTER;
		if (roll < 44) return pst_pkg::CMD_UNREGISTER;
		if (roll < 54) return pst_pkg::CMD_ENTER_WAIT;
		if (roll < 64) return pst_pkg::CMD_LEAVE_WAIT;
		if (roll < 84) return pst_pkg::CMD_UPDATE;
		return pst_pkg::CMD_COMPUTE;
	endfunction

	initial begin
		logic [2:0] op;
		bit         growing;

		occupancy_sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. A compute over an empty table returns all ones and
		// keeps the cached minimum at zero.
		send_command(pst_pkg::CMD_COMPUTE, 1'b0, 4'd0, '0);
		// Unregistering a slot that was never active still counts down, held at zero.
		send_command(pst_pkg::CMD_UNREGISTER, 1'b1, 4'd3, '0);
		// The two unused codes change nothing.
		send_command(3'd6, 1'b1, 4'd15, pst_pkg::ALL_ONES);
		send_command(3'd7, 1'b1, 4'd0, pst_pkg::ALL_ONES);
		// First worker lands in slot 0 seeded with zero; then a single active
		// slot makes compute report all ones while caching its value.
		send_command(pst_pkg::CMD_REGISTER, 1'b0, 4'd0, '0);
		send_command(pst_pkg::CMD_UPDATE, 1'b1, 4'd0, pst_pkg::ALL_ONES);
		send_command(pst_pkg::CMD_COMPUTE, 1'b1, 4'd0, '0);
		// Second worker is seeded with the all-ones cached minimum; two active
		// slots make compute return the real minimum.
		send_command(pst_pkg::CMD_REGISTER, 1'b1, 4'd7, '0);
		send_command(pst_pkg::CMD_UPDATE, 1'b1, 4'd1, '0);
		send_command(pst_pkg::CMD_COMPUTE, 1'b0, 4'd0, '0);
		// With no slot named, the slot commands are no-ops.
		send_command(pst_pkg::CMD_UPDATE, 1'b0, 4'd1, 64'd5);
		send_command(pst_pkg::CMD_UNREGISTER, 1'b0, 4'd1, '0);
		// A waiting worker frees its slot: register takes it back and counts again.
		send_command(pst_pkg::CMD_ENTER_WAIT, 1'b1, 4'd0, '0);
		send_command(pst_pkg::CMD_LEAVE_WAIT, 1'b0, 4'd0, '0);
		send_command(pst_pkg::CMD_REGISTER, 1'b1, 4'd0, '0);
		// Leave wait on the top slot reseeds it and activates it; update an
		// inactive slot too.
		send_command(pst_pkg::CMD_LEAVE_WAIT, 1'b1, 4'd15, '0);
		send_command(pst_pkg::CMD_UPDATE, 1'b1, 4'd9, 64'h8000_0000_0000_0000);
		// Fill the rest of the table, then one register that must fail.
		repeat (SLOTS - 3)
			send_command(pst_pkg::CMD_REGISTER, 1'b1, 4'd0, '0);
		send_command(pst_pkg::CMD_REGISTER, 1'b1, 4'd0, '0);
		send_command(pst_pkg::CMD_COMPUTE, 1'b1, 4'd0, '0);

		// Random part, alternating growing and shrinking phases of 200 commands.
		for (int unsigned n = 0; n < RANDOM_COMMANDS; n++) begin
			growing = ((n / 200) % 2) == 0;
			op = pick_command(growing);
			send_command(op, ($urandom_range(99) >= 8), 4'($urandom_range(SLOTS - 1)),
				pick_progress());
		end
		in_valid <= 1'b0;

		// Wait for every predicted result, then linger so that any stray extra
		// result would still be caught by the output monitor.
		while (occupancy_sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (occupancy_sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
